// ----- rtl/core/linear_scan_register_allocator_defines.svh -----
// Assertion macros for the linear scan register allocator.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef LINEAR_SCAN_REGISTER_ALLOCATOR_DEFINES_SVH
`define LINEAR_SCAN_REGISTER_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define LSRA_ASSERT_IMPL(label, ck, rn, cond, prop) \
  label: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (prop)) \
    else $error("lsra: check failed");
`define LSRA_ASSERT_NEXT(label, ck, rn, cond, prop) \
  label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (prop)) \
    else $error("lsra: check failed");
`else
`define LSRA_ASSERT_IMPL(label, ck, rn, cond, prop)
`define LSRA_ASSERT_NEXT(label, ck, rn, cond, prop)
`endif

`endif

// ----- rtl/core/lsra_pkg.sv -----
// Shared types, widths and helpers of the linear scan register allocator.
// Used by the interfaces and by every module of the block but lsra_ram; depends on nothing.
package lsra_pkg;

  localparam int MAX_REGS   = 16;
  localparam int IDX_W      = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int CNT_W      = $clog2(MAX_REGS + 1);
  localparam int RING_DEPTH = 1 << IDX_W;

  localparam int NUMREGS_W = 5;
  localparam int POS_W     = 16;
  localparam int TAG_W     = 16;
  localparam int SIZE_W    = 7;
  localparam int REG_W     = 4;
  localparam int OFF_W     = 16;

  typedef struct packed {
    logic [POS_W-1:0]  end_pos;
    logic [REG_W-1:0]  reg_num;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } act_entry_t;

  localparam int ENTRY_W = $bits(act_entry_t);

  typedef struct packed {
    logic [TAG_W-1:0] result_tag;
    logic             spilled;
    logic [REG_W-1:0] reg_index;
    logic [OFF_W-1:0] stack_offset;
    logic             stack_overflow;
    logic             last;
  } res_t;

  // Commands from the sequencer to the free register stack.
  typedef struct packed {
    logic             refill;
    logic [CNT_W-1:0] refill_k;
    logic             push;
    logic [REG_W-1:0] push_reg;
    logic             pop;
  } fs_ctl_t;

  // Register count clamped to 1..MAX_REGS.
  function automatic logic [CNT_W-1:0] eff_regs(input logic [NUMREGS_W-1:0] n);
    logic [CNT_W-1:0] k;
    if (n == '0) begin
      k = CNT_W'(1);
    end else if (int'(n) > MAX_REGS) begin
      k = CNT_W'(MAX_REGS);
    end else begin
      k = CNT_W'(n);
    end
    return k;
  endfunction

endpackage

// ----- rtl/core/lsra_if.sv -----
// Valid/ready channel interfaces of the allocator: interval input and result output.
// Depend on lsra_pkg for the field widths.
interface lsra_in_if;
  import lsra_pkg::*;

  logic              valid;
  logic              ready;
  logic              start_run;
  logic              clear_stack;
  logic [TAG_W-1:0]  interval_tag;
  logic [POS_W-1:0]  live_begin;
  logic [POS_W-1:0]  live_end;
  logic [SIZE_W-1:0] spill_bytes;

  modport source (output valid, start_run, clear_stack, interval_tag, live_begin,
                  live_end, spill_bytes, input ready);
  modport sink   (input valid, start_run, clear_stack, interval_tag, live_begin,
                  live_end, spill_bytes, output ready);
endinterface

interface lsra_out_if;
  import lsra_pkg::*;

  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] result_tag;
  logic             spilled;
  logic [REG_W-1:0] reg_index;
  logic [OFF_W-1:0] stack_offset;
  logic             stack_overflow;
  logic             last;

  modport source (output valid, result_tag, spilled, reg_index, stack_offset,
                  stack_overflow, last, input ready);
  modport sink   (input valid, result_tag, spilled, reg_index, stack_offset,
                  stack_overflow, last, output ready);
endinterface

// ----- rtl/core/linear_scan_register_allocator.sv -----
// Top level of the linear scan register allocator: sequencer, shared compare unit,
// spill slot allocator. Depends on lsra_pkg, lsra_if, lsra_ram, lsra_free_stack,
// lsra_out_queue and the assertion macro header.
//
// Channel  Role    Handshake    Fields
// in_ch    sink    valid/ready  start_run clear_stack interval_tag live_begin live_end spill_bytes
// out_ch   source  valid/ready  result_tag spilled reg_index stack_offset stack_overflow last
// cfg      write   cfg_we       cfg_wdata (num_regs)
//
// From acceptance the sequencer reads the list head, retires the entries that end before
// the new begin, then takes a free register, evicts the latest-ending entry or spills the
// item itself; a taken register goes in by sorted insertion, which moves later-ending
// entries up. The active list RAM has one read port, walked an entry a cycle. in_ready
// is high whenever the sequencer is idle, as it is out of reset. The final state waits
// while the two-item result queue lacks room for the results.
`include "linear_scan_register_allocator_defines.svh"

module linear_scan_register_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  lsra_in_if.sink                          in_ch,
  lsra_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [lsra_pkg::NUMREGS_W-1:0]   cfg_wdata
);
  import lsra_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_RET_RD  = 8'b0000_0010,
    S_RET_CHK = 8'b0000_0100,
    S_DECIDE  = 8'b0000_1000,
    S_EVT_CHK = 8'b0001_0000,
    S_INS_RD  = 8'b0010_0000,
    S_INS_CHK = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_t;

  state_t st_r, st_nxt;

  logic [NUMREGS_W-1:0] num_regs_r;
  logic [CNT_W-1:0]     k_eff;

  // Latched item.
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [POS_W-1:0]  beg_r, beg_nxt;
  logic [POS_W-1:0]  endp_r, endp_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;

  // Active list ring.
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] act_cnt_r, act_cnt_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [REG_W-1:0] new_reg_r, new_reg_nxt;
  logic [IDX_W-1:0] slot_pos, slot_pm1, slot_pm2, slot_tail;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  act_entry_t       rd, new_ent;

  // Shared compare unit.
  logic [POS_W-1:0] cmp_b;
  logic             rd_lt, rd_gt;

  // Spill slot allocator.
  logic [OFF_W-1:0]  stack_top_r, stack_top_nxt;
  logic [SIZE_W-1:0] alloc_size;
  logic [OFF_W:0]    alloc_sum;
  logic              alloc_ovf;
  logic [OFF_W-1:0]  alloc_off, alloc_top;

  res_t       res_a_r, res_a_nxt, res_b_r, res_b_nxt;
  logic [1:0] res_n_r, res_n_nxt;
  logic [1:0] q_push_n, q_count;
  logic [2:0] q_need;

  fs_ctl_t          fs_ctl;
  logic [REG_W-1:0] fs_top;
  logic [CNT_W-1:0] fs_cnt;
  logic [CNT_W:0]   reg_budget;

  assign k_eff = eff_regs(num_regs_r);

  assign rd = act_entry_t'(ram_rdata);

  assign slot_pos  = head_r + pos_r[IDX_W-1:0];
  assign slot_pm1  = slot_pos - IDX_W'(1);
  assign slot_pm2  = slot_pos - IDX_W'(2);
  assign slot_tail = head_r + act_cnt_r[IDX_W-1:0] - IDX_W'(1);

  always_comb begin
    new_ent.end_pos = endp_r;
    new_ent.reg_num = new_reg_r;
    new_ent.tag     = tag_r;
    new_ent.size    = size_r;
  end

  // Retirement asks "ends before the new begin", eviction and insertion ask
  // "ends after the new end"; one shared compare unit serves all three.
  assign cmp_b = (st_r == S_RET_CHK) ? beg_r : endp_r;
  assign rd_lt = (rd.end_pos < cmp_b);
  assign rd_gt = (rd.end_pos > cmp_b);

  assign alloc_size = (st_r == S_EVT_CHK && rd_gt) ? rd.size : size_r;
  assign alloc_sum  = {1'b0, stack_top_r} + (OFF_W + 1)'(alloc_size);
  assign alloc_ovf  = alloc_sum[OFF_W];
  assign alloc_off  = alloc_ovf ? '1 : stack_top_r;
  assign alloc_top  = alloc_ovf ? '1 : alloc_sum[OFF_W-1:0];

  assign q_need = {1'b0, q_count} + {1'b0, res_n_r};

  assign in_ch.ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt        = st_r;
    tag_nxt       = tag_r;
    beg_nxt       = beg_r;
    endp_nxt      = endp_r;
    size_nxt      = size_r;
    head_nxt      = head_r;
    act_cnt_nxt   = act_cnt_r;
    pos_nxt       = pos_r;
    new_reg_nxt   = new_reg_r;
    stack_top_nxt = stack_top_r;
    res_a_nxt     = res_a_r;
    res_b_nxt     = res_b_r;
    res_n_nxt     = res_n_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_pos;
    ram_wdata     = new_ent;
    ram_raddr     = head_r;
    q_push_n      = 2'd0;
    fs_ctl          = '0;
    fs_ctl.refill_k = k_eff;
    fs_ctl.push_reg = rd.reg_num;

    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          tag_nxt  = in_ch.interval_tag;
          beg_nxt  = in_ch.live_begin;
          endp_nxt = in_ch.live_end;
          size_nxt = in_ch.spill_bytes;
          if (in_ch.start_run) begin
            act_cnt_nxt   = '0;
            fs_ctl.refill = 1'b1;
          end
          if (in_ch.clear_stack) begin
            stack_top_nxt = '0;
          end
          st_nxt = S_RET_RD;
        end
      end

      S_RET_RD: begin
        ram_raddr = head_r;
        st_nxt    = (act_cnt_r == '0) ? S_DECIDE : S_RET_CHK;
      end

      S_RET_CHK: begin
        if (rd_lt) begin
          fs_ctl.push = 1'b1;
          head_nxt    = head_r + IDX_W'(1);
          act_cnt_nxt = act_cnt_r - CNT_W'(1);
          ram_raddr   = head_r + IDX_W'(1);
          st_nxt      = (act_cnt_r > CNT_W'(1)) ? S_RET_CHK : S_DECIDE;
        end else begin
          st_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (act_cnt_r < k_eff && fs_cnt != '0 && act_cnt_r < CNT_W'(MAX_REGS)) begin
          fs_ctl.pop               = 1'b1;
          new_reg_nxt              = fs_top;
          pos_nxt                  = act_cnt_r;
          res_a_nxt.result_tag     = tag_r;
          res_a_nxt.spilled        = 1'b0;
          res_a_nxt.reg_index      = fs_top;
          res_a_nxt.stack_offset   = '0;
          res_a_nxt.stack_overflow = 1'b0;
          res_a_nxt.last           = 1'b1;
          res_n_nxt                = 2'd1;
          st_nxt                   = S_INS_RD;
        end else if (act_cnt_r != '0) begin
          ram_raddr = slot_tail;
          st_nxt    = S_EVT_CHK;
        end else begin
          stack_top_nxt            = alloc_top;
          res_a_nxt.result_tag     = tag_r;
          res_a_nxt.spilled        = 1'b1;
          res_a_nxt.reg_index      = '0;
          res_a_nxt.stack_offset   = alloc_off;
          res_a_nxt.stack_overflow = alloc_ovf;
          res_a_nxt.last           = 1'b1;
          res_n_nxt                = 2'd1;
          st_nxt                   = S_EMIT;
        end
      end

      S_EVT_CHK: begin
        stack_top_nxt = alloc_top;
        if (rd_gt) begin
          // The latest-ending entry gives up its register and goes to the stack.
          res_a_nxt.result_tag     = rd.tag;
          res_a_nxt.spilled        = 1'b1;
          res_a_nxt.reg_index      = '0;
          res_a_nxt.stack_offset   = alloc_off;
          res_a_nxt.stack_overflow = alloc_ovf;
          res_a_nxt.last           = 1'b0;
          res_b_nxt.result_tag     = tag_r;
          res_b_nxt.spilled        = 1'b0;
          res_b_nxt.reg_index      = rd.reg_num;
          res_b_nxt.stack_offset   = '0;
          res_b_nxt.stack_overflow = 1'b0;
          res_b_nxt.last           = 1'b1;
          res_n_nxt                = 2'd2;
          new_reg_nxt              = rd.reg_num;
          act_cnt_nxt              = act_cnt_r - CNT_W'(1);
          pos_nxt                  = act_cnt_r - CNT_W'(1);
          st_nxt                   = S_INS_RD;
        end else begin
          res_a_nxt.result_tag     = tag_r;
          res_a_nxt.spilled        = 1'b1;
          res_a_nxt.reg_index      = '0;
          res_a_nxt.stack_offset   = alloc_off;
          res_a_nxt.stack_overflow = alloc_ovf;
          res_a_nxt.last           = 1'b1;
          res_n_nxt                = 2'd1;
          st_nxt                   = S_EMIT;
        end
      end

      S_INS_RD: begin
        if (pos_r == '0) begin
          ram_we      = 1'b1;
          ram_waddr   = slot_pos;
          ram_wdata   = new_ent;
          act_cnt_nxt = act_cnt_r + CNT_W'(1);
          st_nxt      = S_EMIT;
        end else begin
          ram_raddr = slot_pm1;
          st_nxt    = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        if (rd_gt) begin
          // Move the later-ending entry up one place and look at the next one down.
          ram_we    = 1'b1;
          ram_waddr = slot_pos;
          ram_wdata = rd;
          ram_raddr = slot_pm2;
          pos_nxt   = pos_r - CNT_W'(1);
          st_nxt    = (pos_r > CNT_W'(1)) ? S_INS_CHK : S_INS_RD;
        end else begin
          ram_we      = 1'b1;
          ram_waddr   = slot_pos;
          ram_wdata   = new_ent;
          act_cnt_nxt = act_cnt_r + CNT_W'(1);
          st_nxt      = S_EMIT;
        end
      end

      S_EMIT: begin
        if (q_need <= 3'd2) begin
          q_push_n = res_n_r;
          st_nxt   = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      num_regs_r  <= NUMREGS_W'(MAX_REGS);
      head_r      <= '0;
      act_cnt_r   <= '0;
      stack_top_r <= '0;
      res_n_r     <= 2'd0;
    end else begin
      st_r        <= st_nxt;
      num_regs_r  <= cfg_we ? cfg_wdata : num_regs_r;
      head_r      <= head_nxt;
      act_cnt_r   <= act_cnt_nxt;
      stack_top_r <= stack_top_nxt;
      res_n_r     <= res_n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r     <= tag_nxt;
    beg_r     <= beg_nxt;
    endp_r    <= endp_nxt;
    size_r    <= size_nxt;
    pos_r     <= pos_nxt;
    new_reg_r <= new_reg_nxt;
    res_a_r   <= res_a_nxt;
    res_b_r   <= res_b_nxt;
  end

  lsra_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_act_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lsra_free_stack u_free_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fs_ctl),
    .top_reg (fs_top),
    .count   (fs_cnt)
  );

  lsra_out_queue u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_n  (q_push_n),
    .push_a  (res_a_r),
    .push_b  (res_b_r),
    .q_count (q_count),
    .out_ch  (out_ch)
  );

  // Registers are conserved: free plus active never exceeds the class size.
  assign reg_budget = {1'b0, fs_cnt} + {1'b0, act_cnt_r};

  `LSRA_ASSERT_IMPL(a_reg_budget, clk, rst_n, st_r == S_IDLE, reg_budget <= (CNT_W + 1)'(MAX_REGS))
  `LSRA_ASSERT_IMPL(a_act_bound, clk, rst_n, 1'b1, act_cnt_r <= CNT_W'(MAX_REGS))
  `LSRA_ASSERT_NEXT(a_accept_walk, clk, rst_n, in_ch.valid && in_ch.ready, st_r == S_RET_RD)

endmodule

// ----- rtl/core/lsra_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the active interval ring; depends on nothing.
module lsra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/lsra_free_stack.sv -----
// LIFO of free physical registers, refilled in descending order.
// Depends on lsra_pkg for the command struct and widths.
module lsra_free_stack (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lsra_pkg::fs_ctl_t       ctl,
  output logic [lsra_pkg::REG_W-1:0] top_reg,
  output logic [lsra_pkg::CNT_W-1:0] count
);
  import lsra_pkg::*;

  logic [REG_W-1:0] stk_r   [MAX_REGS];
  logic [REG_W-1:0] stk_nxt [MAX_REGS];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] top_idx;

  always_comb begin
    stk_nxt = stk_r;
    cnt_nxt = cnt_r;
    if (ctl.refill) begin
      // Register zero ends up on top.
      for (int i = 0; i < MAX_REGS; i++) begin
        if (i < int'(ctl.refill_k)) begin
          stk_nxt[i] = REG_W'(int'(ctl.refill_k) - 1 - i);
        end
      end
      cnt_nxt = ctl.refill_k;
    end else if (ctl.push) begin
      if (cnt_r < CNT_W'(MAX_REGS)) begin
        stk_nxt[cnt_r[IDX_W-1:0]] = ctl.push_reg;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else if (ctl.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_REGS; i++) begin
        stk_r[i] <= REG_W'(MAX_REGS - 1 - i);
      end
      cnt_r <= CNT_W'(MAX_REGS);
    end else begin
      stk_r <= stk_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign top_idx = IDX_W'(cnt_r - CNT_W'(1));
  assign top_reg = stk_r[top_idx];
  assign count   = cnt_r;

endmodule

// ----- rtl/core/lsra_out_queue.sv -----
// Two-item result queue that drives the output channel.
// Depends on lsra_pkg, lsra_if and the assertion macro header.
`include "linear_scan_register_allocator_defines.svh"

module lsra_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_n,
  input  lsra_pkg::res_t     push_a,
  input  lsra_pkg::res_t     push_b,
  output logic [1:0]         q_count,
  lsra_out_if.source         out_ch
);
  import lsra_pkg::*;

  res_t       q_r   [2];
  res_t       q_nxt [2];
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic [1:0] c_after_pop;
  logic [2:0] fill_after;
  logic       pop;

  assign pop         = out_ch.valid && out_ch.ready;
  assign c_after_pop = q_cnt_r - {1'b0, pop};
  assign fill_after  = {1'b0, c_after_pop} + {1'b0, push_n};

  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    if (push_n != 2'd0) begin
      if (c_after_pop == 2'd0) begin
        q_nxt[0] = push_a;
        if (push_n == 2'd2) begin
          q_nxt[1] = push_b;
        end
      end else begin
        q_nxt[1] = push_a;
      end
    end
    q_cnt_nxt = fill_after[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_count               = q_cnt_r;
  assign out_ch.valid          = (q_cnt_r != 2'd0);
  assign out_ch.result_tag     = q_r[0].result_tag;
  assign out_ch.spilled        = q_r[0].spilled;
  assign out_ch.reg_index      = q_r[0].reg_index;
  assign out_ch.stack_offset   = q_r[0].stack_offset;
  assign out_ch.stack_overflow = q_r[0].stack_overflow;
  assign out_ch.last           = q_r[0].last;

  // The sequencer must only hand over results when there is room for all of them.
  `LSRA_ASSERT_IMPL(a_q_no_overflow, clk, rst_n, push_n != 2'd0, fill_after <= 3'd2)
  // An eviction pair is the spill of the old entry followed by the closing result.
  `LSRA_ASSERT_IMPL(a_q_pair_order, clk, rst_n, push_n == 2'd2, !push_a.last && push_b.last)
  // A waiting result is not withdrawn.
  `LSRA_ASSERT_NEXT(a_q_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)

endmodule

// ----- sim/lsra_checker.sv -----
// Scoreboard of the linear scan register allocator: watches both channels and the
// register write port, predicts every result and compares it field by field.
// Depends on lsra_pkg and the channel interfaces in lsra_if.
module lsra_checker
  import lsra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  lsra_in_if                   in_ch,
  lsra_out_if                  out_ch,
  input  logic                 cfg_we,
  input  logic [NUMREGS_W-1:0] cfg_wdata,
  output int                   n_failed,
  output int                   n_waiting
);

  localparam logic [NUMREGS_W-1:0] REGS_AT_RESET = NUMREGS_W'(16);

  // Active intervals, kept sorted by end position.
  logic [POS_W-1:0]     list_end [MAX_REGS];
  logic [REG_W-1:0]     list_reg [MAX_REGS];
  logic [TAG_W-1:0]     list_tag [MAX_REGS];
  logic [SIZE_W-1:0]    list_size[MAX_REGS];
  int                   list_len;
  logic [REG_W-1:0]     idle_regs[MAX_REGS];
  int                   free_len;
  logic [OFF_W-1:0]     slot_top;
  logic [NUMREGS_W-1:0] regs_cfg;
  res_t                 expected_q[$];

  function automatic int usable_regs();
    if (regs_cfg == '0) return 1;
    if (int'(regs_cfg) > MAX_REGS) return MAX_REGS;
    return int'(regs_cfg);
  endfunction

  function automatic res_t make_res(input logic [TAG_W-1:0] tag, input logic sp,
                                    input logic [REG_W-1:0] r, input logic [OFF_W-1:0] off,
                                    input logic ovf, input logic fin);
    res_t x;
    x.result_tag     = tag;
    x.spilled        = sp;
    x.reg_index      = r;
    x.stack_offset   = off;
    x.stack_overflow = ovf;
    x.last           = fin;
    return x;
  endfunction

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    n_failed++;
  endtask

  task automatic refill_free();
    int k;
    k = usable_regs();
    for (int i = 0; i < k; i++) idle_regs[i] = REG_W'(k - 1 - i);
    free_len = k;
    list_len = 0;
  endtask

  // Bump allocation of a spill slot; the offset sticks at its ceiling once it overflows.
  task automatic take_slot(input logic [SIZE_W-1:0] bytes, output logic [OFF_W-1:0] off,
                           output logic ovf);
    int nxt;
    nxt = int'(slot_top) + int'(bytes);
    if (nxt > 65535) begin
      slot_top = 16'hFFFF;
      off      = 16'hFFFF;
      ovf      = 1'b1;
    end else begin
      off      = slot_top;
      ovf      = 1'b0;
      slot_top = OFF_W'(nxt);
    end
  endtask

  // Sorted insertion; an equal end goes behind the entries already there.
  task automatic place(input logic [POS_W-1:0] fin, input logic [REG_W-1:0] r,
                       input logic [TAG_W-1:0] tag, input logic [SIZE_W-1:0] bytes);
    int p;
    p = list_len;
    if (list_len >= MAX_REGS) return;
    while (p > 0 && list_end[p-1] > fin) begin
      list_end[p]  = list_end[p-1];
      list_reg[p]  = list_reg[p-1];
      list_tag[p]  = list_tag[p-1];
      list_size[p] = list_size[p-1];
      p--;
    end
    list_end[p]  = fin;
    list_reg[p]  = r;
    list_tag[p]  = tag;
    list_size[p] = bytes;
    list_len++;
  endtask

  task automatic allocate_interval(input logic sr, input logic cs,
                                   input logic [TAG_W-1:0] tag, input logic [POS_W-1:0] beg,
                                   input logic [POS_W-1:0] fin,
                                   input logic [SIZE_W-1:0] bytes);
    int              gone;
    int              v;
    logic [OFF_W-1:0] off;
    logic            ovf;
    logic [REG_W-1:0] r;
    gone = 0;
    if (sr) refill_free();
    if (cs) slot_top = '0;
    while (gone < list_len && list_end[gone] < beg) begin
      if (free_len < MAX_REGS) begin
        idle_regs[free_len] = list_reg[gone];
        free_len++;
      end
      gone++;
    end
    for (int i = gone; i < list_len; i++) begin
      list_end[i-gone]  = list_end[i];
      list_reg[i-gone]  = list_reg[i];
      list_tag[i-gone]  = list_tag[i];
      list_size[i-gone] = list_size[i];
    end
    list_len -= gone;

    if (list_len < usable_regs() && free_len > 0 && list_len < MAX_REGS) begin
      free_len--;
      r = idle_regs[free_len];
      place(fin, r, tag, bytes);
      expected_q.insert(expected_q.size(), make_res(tag, 1'b0, r, '0, 1'b0, 1'b1));
    end else if (list_len > 0 && list_end[list_len-1] > fin) begin
      // The interval living longest gives up its register and goes to the stack.
      v = list_len - 1;
      r = list_reg[v];
      take_slot(list_size[v], off, ovf);
      expected_q.insert(expected_q.size(), make_res(list_tag[v], 1'b1, '0, off, ovf, 1'b0));
      list_len--;
      place(fin, r, tag, bytes);
      expected_q.insert(expected_q.size(), make_res(tag, 1'b0, r, '0, 1'b0, 1'b1));
    end else begin
      take_slot(bytes, off, ovf);
      expected_q.insert(expected_q.size(), make_res(tag, 1'b1, '0, off, ovf, 1'b1));
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input logic [TAG_W-1:0] tag);
    if (got !== want)
      report($sformatf("item %h: %s is %0h, predicted %0h", tag, name, got, want));
  endtask

  task automatic check_result();
    res_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("result for tag %h arrived with nothing outstanding",
                       out_ch.result_tag));
    end else begin
      want = expected_q.pop_front();
      compare_field("result_tag", 32'(out_ch.result_tag), 32'(want.result_tag),
                    want.result_tag);
      compare_field("spilled", 32'(out_ch.spilled), 32'(want.spilled), want.result_tag);
      compare_field("reg_index", 32'(out_ch.reg_index), 32'(want.reg_index),
                    want.result_tag);
      compare_field("stack_offset", 32'(out_ch.stack_offset), 32'(want.stack_offset),
                    want.result_tag);
      compare_field("stack_overflow", 32'(out_ch.stack_overflow),
                    32'(want.stack_overflow), want.result_tag);
      compare_field("last", 32'(out_ch.last), 32'(want.last), want.result_tag);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_failed = 0;
      regs_cfg = REGS_AT_RESET;
      slot_top = '0;
      refill_free();
      expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_we) regs_cfg = cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        allocate_interval(in_ch.start_run, in_ch.clear_stack, in_ch.interval_tag,
                          in_ch.live_begin, in_ch.live_end, in_ch.spill_bytes);
    end
    n_waiting = expected_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the allocator testbench: clock, reset, interval stimulus, result back-pressure
// and the verdict. Depends on lsra_pkg, lsra_if, lsra_checker and the allocator RTL.
module testbench;
  import lsra_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [NUMREGS_W-1:0] cfg_wdata;
  int                   n_failed;
  int                   n_waiting;
  int                   burst_left = 0;
  bit                   squeeze = 1'b0;

  lsra_in_if  in_ch();
  lsra_out_if out_ch();

  linear_scan_register_allocator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  lsra_checker i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .n_failed (n_failed),
    .n_waiting(n_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one item and returns at the edge where it is taken. Items come in bursts.
  task automatic send_interval(input logic sr, input logic cs, input logic [TAG_W-1:0] tag,
                               input logic [POS_W-1:0] beg, input logic [POS_W-1:0] fin,
                               input logic [SIZE_W-1:0] bytes);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.start_run    <= sr;
    in_ch.clear_stack  <= cs;
    in_ch.interval_tag <= tag;
    in_ch.live_begin   <= beg;
    in_ch.live_end     <= fin;
    in_ch.spill_bytes  <= bytes;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // The register count only changes once every outstanding result has drained.
  task automatic set_regs(input logic [NUMREGS_W-1:0] n);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (n_waiting == 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Runs of intervals with rising begins, mixed with the odd malformed item.
  task automatic random_phase(input int n_items, input int max_step, input int len_lo,
                              input int len_hi, input int size_lo, input int size_hi,
                              input bit clears, input bit first_fresh, input int squeeze_at);
    int   done;
    int   run_len;
    int   pos;
    int   fin;
    bit   fresh;
    logic sr;
    logic cs;
    logic [SIZE_W-1:0] bytes;
    done  = 0;
    fresh = first_fresh;
    while (done < n_items) begin
      run_len = $urandom_range(4, 40);
      pos = ($urandom_range(0, 7) == 0) ? $urandom_range(60000, 65535)
                                        : $urandom_range(0, 20000);
      for (int k = 0; k < run_len && done < n_items; k++) begin
        if (done == squeeze_at) squeeze = 1'b1;
        sr = (k == 0) ? (fresh && $urandom_range(0, 4) != 0) : ($urandom_range(0, 63) == 0);
        cs = clears && ($urandom_range(0, 15) == 0);
        pos += $urandom_range(0, max_step);
        if (pos > 65535) pos = 65535;
        fin = pos + $urandom_range(len_lo, len_hi);
        if (fin > 65535) fin = 65535;
        bytes = SIZE_W'($urandom_range(size_lo, size_hi));
        if ($urandom_range(0, 11) == 0) begin
          // Malformed: positions anywhere, end possibly below begin.
          send_interval(sr, cs, TAG_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                        SIZE_W'($urandom_range(0, 127)));
        end else begin
          send_interval(sr, cs, TAG_W'($urandom), POS_W'(pos), POS_W'(fin), bytes);
        end
        done++;
      end
      fresh = 1'b1;
    end
  endtask

  initial begin : result_sink
    int  seg_left;
    int  mode;
    int  cyc;
    bit  held;
    seg_left = 0;
    mode     = 0;
    cyc      = 0;
    held     = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (squeeze && !held) begin
        // Long hold-off so that the result queue fills and the input backs up.
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(16, 160);
      end
      seg_left--;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (cyc % 3 != 0);
      endcase
    end
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.start_run    <= 1'b0;
    in_ch.clear_stack  <= 1'b0;
    in_ch.interval_tag <= '0;
    in_ch.live_begin   <= '0;
    in_ch.live_end     <= '0;
    in_ch.spill_bytes  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes with the register count left at its reset value.
    send_interval(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 7'h00);
    send_interval(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F);

    // Two registers: free allocation, eviction, self spill, retirement and ties.
    set_regs(5'd2);
    send_interval(1'b1, 1'b1, 16'd1, 16'd10, 16'd100, 7'd8);
    send_interval(1'b0, 1'b0, 16'd2, 16'd11, 16'd50, 7'd4);
    send_interval(1'b0, 1'b0, 16'd3, 16'd12, 16'd60, 7'd16);
    send_interval(1'b0, 1'b0, 16'd4, 16'd13, 16'd200, 7'd5);
    send_interval(1'b0, 1'b0, 16'd5, 16'd55, 16'd70, 7'd64);
    send_interval(1'b0, 1'b0, 16'd6, 16'd56, 16'd70, 7'd0);
    send_interval(1'b0, 1'b0, 16'd7, 16'd600, 16'd300, 7'd33);
    send_interval(1'b0, 1'b1, 16'd8, 16'd600, 16'd600, 7'd1);
    send_interval(1'b0, 1'b0, 16'd9, 16'd600, 16'd600, 7'd2);
    send_interval(1'b0, 1'b0, 16'd10, 16'd600, 16'd600, 7'd3);
    send_interval(1'b1, 1'b0, 16'h5555, 16'h0000, 16'hAAAA, 7'h55);
    send_interval(1'b0, 1'b0, 16'hAAAA, 16'h0001, 16'h5555, 7'h2A);

    // A count of zero behaves as a single register.
    set_regs(5'd0);
    random_phase(100, 4, 0, 40, 0, 64, 1'b1, 1'b1, -1);
    set_regs(5'd16);
    random_phase(120, 3, 20, 200, 1, 64, 1'b1, 1'b1, 40);
    set_regs(5'd31);
    random_phase(50, 3, 0, 120, 0, 127, 1'b1, 1'b1, -1);
    // Shrink the count without a new run so the list starts out over-full.
    set_regs(5'd5);
    random_phase(70, 3, 0, 80, 1, 64, 1'b1, 1'b0, -1);
    // One register, long intervals and big slots: drives the stack offset into saturation.
    set_regs(5'd1);
    random_phase(700, 1, 50, 300, 112, 127, 1'b0, 1'b1, -1);
    set_regs(5'd17);
    random_phase(50, 4, 0, 100, 0, 127, 1'b1, 1'b1, -1);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (n_waiting == 0);
    repeat (60) @(posedge clk);
    if (n_failed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- linear_scan_register_allocator.f -----
+incdir+rtl/core
rtl/core/lsra_pkg.sv
rtl/core/lsra_if.sv
rtl/core/lsra_ram.sv
rtl/core/lsra_free_stack.sv
rtl/core/lsra_out_queue.sv
rtl/core/linear_scan_register_allocator.sv
sim/lsra_checker.sv
sim/testbench.sv
